/* src/knn_pkg.sv */
package knn_pkg;

  localparam int COORD_BITS    = 16;
  localparam int DIST_W        = 39;
  localparam int IDX_W         = 16;
  localparam int KCFG_W        = 5;
  localparam int DCFG_W        = 7;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int DIM_MAX_DEF   = 64;
  localparam int K_MAX_DEF     = 16;
  localparam int TRAIN_MAX_DEF = 65536;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_TRAIN = 2'd2,
    ACT_EMIT  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_COUNT = 1'b0,
    REG_DIMS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_INS,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    action_t                        action;
    logic signed [COORD_BITS-1:0]   coord_value;
  } knn_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  neighbor_index;
    logic [DIST_W-1:0] neighbor_distance;
    logic              last_result;
  } knn_out_t;

  typedef struct packed {
    logic              clear;
    logic              insert;
    logic [DIST_W-1:0] cand_dist;
    logic [IDX_W-1:0]  idx;
  } list_ctl_t;

  // Offset-binary form keeps the order of signed coordinates as unsigned values.
  function automatic logic [COORD_BITS-1:0] coord_bias(input logic [COORD_BITS-1:0] c);
    coord_bias = {~c[COORD_BITS-1], c[COORD_BITS-2:0]};
  endfunction

endpackage

/* src/knn_front.sv */
module knn_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_start,
  input  knn_pkg::knn_in_t in_data,
  output logic             busy,
  input  logic             pop,
  output logic             q_valid,
  output knn_pkg::knn_in_t q_item
);
  import knn_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  knn_in_t          entry_r [QUEUE_DEPTH];
  logic [QPW-1:0]   head_r, head_nxt;
  logic [QPW-1:0]   tail_r, tail_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push;
  logic             do_pop;

  assign busy    = (cnt_r == QCW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = entry_r[head_r];
  assign push    = in_start && !busy;
  assign do_pop  = pop && q_valid;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= in_data;
    end
  end

endmodule

/* src/knn_list.sv */
module knn_list #(
  parameter int K_MAX = knn_pkg::K_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  knn_pkg::list_ctl_t                         ctl,
  input  logic [$clog2(K_MAX+1)-1:0]                 eff_k,
  input  logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] rd_rank,
  output logic [knn_pkg::DIST_W-1:0]                 rd_dist,
  output logic [knn_pkg::IDX_W-1:0]                  rd_idx
);
  import knn_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  localparam int KI = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [DIST_W-1:0] best_d_r   [K_MAX];
  logic [DIST_W-1:0] best_d_nxt [K_MAX];
  logic [IDX_W-1:0]  best_i_r   [K_MAX];
  logic [IDX_W-1:0]  best_i_nxt [K_MAX];
  logic [K_MAX-1:0]  gt;
  logic [K_MAX-1:0]  in_k;
  logic [KI-1:0]     worst;
  logic              enter;

  assign rd_dist = best_d_r[rd_rank];
  assign rd_idx  = best_i_r[rd_rank];
  assign worst   = KI'(eff_k - 1'b1);
  assign enter   = gt[worst];

  // Entries at or below the new distance stay ahead; the rest slide down one slot.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      gt[i]   = (best_d_r[i] > ctl.cand_dist);
      in_k[i] = (KW'(i) < eff_k);
    end
    for (int i = 0; i < K_MAX; i++) begin
      best_d_nxt[i] = best_d_r[i];
      best_i_nxt[i] = best_i_r[i];
      if (ctl.clear) begin
        best_d_nxt[i] = DIST_ONES;
        best_i_nxt[i] = '0;
      end else if (ctl.insert && enter && in_k[i] && gt[i]) begin
        if (i == 0) begin
          best_d_nxt[i] = ctl.cand_dist;
          best_i_nxt[i] = ctl.idx;
        end else if (!gt[(i == 0) ? 0 : i - 1]) begin
          best_d_nxt[i] = ctl.cand_dist;
          best_i_nxt[i] = ctl.idx;
        end else begin
          best_d_nxt[i] = best_d_r[(i == 0) ? 0 : i - 1];
          best_i_nxt[i] = best_i_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < K_MAX; i++) begin
        best_d_r[i] <= DIST_ONES;
        best_i_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < K_MAX; i++) begin
        best_d_r[i] <= best_d_nxt[i];
        best_i_r[i] <= best_i_nxt[i];
      end
    end
  end

endmodule

/* src/knn_back.sv */
module knn_back #(
  parameter int DIM_MAX   = knn_pkg::DIM_MAX_DEF,
  parameter int K_MAX     = knn_pkg::K_MAX_DEF,
  parameter int TRAIN_MAX = knn_pkg::TRAIN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  knn_pkg::knn_in_t                q_item,
  output logic                            pop,
  input  logic                            cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]       cfg_wdata,
  output knn_pkg::list_ctl_t              list_ctl,
  output logic [$clog2(K_MAX+1)-1:0]      eff_k,
  output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] rd_rank,
  input  logic [knn_pkg::DIST_W-1:0]      rd_dist,
  input  logic [knn_pkg::IDX_W-1:0]       rd_idx,
  output logic                            out_strobe,
  output knn_pkg::knn_out_t               out_data
);
  import knn_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  localparam int KI = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int DW = $clog2(DIM_MAX + 1);
  localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int TW = $clog2(TRAIN_MAX + 1);
  localparam int SQ_W = 2 * COORD_BITS;

  back_state_t           state_r, state_nxt;
  logic [KCFG_W-1:0]     k_count_r;
  logic [DCFG_W-1:0]     dims_r;
  logic [DW-1:0]         eff_dims;
  logic [DW-1:0]         fill_r, fill_nxt;
  logic [DW-1:0]         pos_r, pos_nxt;
  logic [DW-1:0]         pos_inc;
  logic [DIST_W-1:0]     acc_r, acc_nxt;
  logic [TW-1:0]         train_r, train_nxt;
  logic [KI-1:0]         rank_r, rank_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  knn_out_t              out_data_r, out_data_nxt;
  logic [COORD_BITS-1:0] coord_r, coord_nxt;
  logic [COORD_BITS-1:0] mag_r, mag_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic [DIST_W:0]       sum;
  logic [DIST_W-1:0]     sum_sat;
  logic                  last_rank;

  // Query coordinate memory, offset-binary.
  logic [COORD_BITS-1:0] qmem [DIM_MAX];
  logic [COORD_BITS-1:0] q_rd_r;
  logic                  qmem_we;
  logic [AW-1:0]         qmem_waddr;
  logic                  qmem_re;
  logic [AW-1:0]         qmem_raddr;

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;
  assign rd_rank    = rank_r;

  always_comb begin
    if (k_count_r == '0) begin
      eff_k = KW'(1);
    end else if (int'(k_count_r) > K_MAX) begin
      eff_k = KW'(K_MAX);
    end else begin
      eff_k = KW'(k_count_r);
    end
    if (dims_r == '0) begin
      eff_dims = DW'(1);
    end else if (int'(dims_r) > DIM_MAX) begin
      eff_dims = DW'(DIM_MAX);
    end else begin
      eff_dims = DW'(dims_r);
    end
  end

  assign pos_inc   = pos_r + 1'b1;
  assign sum       = {1'b0, acc_r} + (DIST_W+1)'(sq_r);
  assign sum_sat   = sum[DIST_W] ? DIST_ONES : sum[DIST_W-1:0];
  assign last_rank = ((KW'(rank_r) + KW'(1)) == eff_k);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    train_nxt      = train_r;
    rank_nxt       = rank_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    coord_nxt      = coord_r;
    mag_nxt        = mag_r;
    sq_nxt         = sq_r;
    dist_nxt       = dist_r;
    pop            = 1'b0;
    qmem_we        = 1'b0;
    qmem_waddr     = fill_r[AW-1:0];
    qmem_re        = 1'b0;
    qmem_raddr     = pos_r[AW-1:0];
    list_ctl.clear     = 1'b0;
    list_ctl.insert    = 1'b0;
    list_ctl.cand_dist = dist_r;
    list_ctl.idx       = IDX_W'(train_r);

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_item.action)
            ACT_CLEAR: begin
              fill_nxt       = '0;
              pos_nxt        = '0;
              acc_nxt        = '0;
              train_nxt      = '0;
              list_ctl.clear = 1'b1;
            end
            ACT_QUERY: begin
              // drop coordinates past the store depth
              if (fill_r < DW'(DIM_MAX)) begin
                qmem_we  = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            ACT_TRAIN: begin
              if (train_r < TW'(TRAIN_MAX)) begin
                qmem_re   = 1'b1;
                coord_nxt = coord_bias(q_item.coord_value);
                state_nxt = ST_DIFF;
              end
            end
            ACT_EMIT: begin
              rank_nxt  = '0;
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIFF: begin
        mag_nxt   = (coord_r >= q_rd_r) ? (coord_r - q_rd_r) : (q_rd_r - coord_r);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        sq_nxt    = mag_r * mag_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (pos_inc >= eff_dims) begin
          dist_nxt  = sum_sat;
          acc_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_INS;
        end else begin
          acc_nxt   = sum_sat;
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end
      end
      ST_INS: begin
        list_ctl.insert = 1'b1;
        train_nxt       = train_r + 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_EMIT: begin
        out_strobe_nxt                 = 1'b1;
        out_data_nxt.neighbor_index    = rd_idx;
        out_data_nxt.neighbor_distance = rd_dist;
        out_data_nxt.last_result       = last_rank;
        if (last_rank) begin
          state_nxt = ST_IDLE;
        end else begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      pos_r        <= '0;
      acc_r        <= '0;
      train_r      <= '0;
      rank_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      train_r      <= train_nxt;
      rank_r       <= rank_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coord_r    <= coord_nxt;
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    dist_r     <= dist_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_count_r <= KCFG_W'(1);
      dims_r    <= DCFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_K_COUNT: k_count_r <= cfg_wdata[KCFG_W-1:0];
        REG_DIMS:    dims_r    <= cfg_wdata[DCFG_W-1:0];
        default:     k_count_r <= k_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (qmem_we) begin
      qmem[qmem_waddr] <= coord_bias(q_item.coord_value);
    end
  end

  always_ff @(posedge clk) begin
    if (qmem_re) begin
      q_rd_r <= qmem[qmem_raddr];
    end
  end

endmodule

/* src/brute_force_knn_search.sv */
// Brute-force K-nearest-neighbor search by squared Euclidean distance. Pulse
// start with an action while busy is low: clear, load a query coordinate, stream
// a training coordinate, or emit the list. A two-entry queue takes commands
// while the datapath works; busy rises only when that queue is full. A clear or
// a query coordinate is taken in the idle state; a training coordinate passes
// through query memory read, difference, square and accumulate, plus list
// insertion on the last coordinate of each point; and an emit walks the ranks,
// one rank per cycle leaving on out_data with out_strobe high for exactly one
// cycle. Results cannot be held off, so the receiver must take every strobe.
// Configuration writes on cfg_we take effect at once and belong to idle periods.
module brute_force_knn_search #(
  parameter int DIM_MAX   = knn_pkg::DIM_MAX_DEF,
  parameter int K_MAX     = knn_pkg::K_MAX_DEF,
  parameter int TRAIN_MAX = knn_pkg::TRAIN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  knn_pkg::knn_in_t              in_data,
  output logic                          busy,
  output logic                          out_strobe,
  output knn_pkg::knn_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_wdata
);
  import knn_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  localparam int KI = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic              q_valid;
  logic              pop;
  knn_in_t           q_item;
  list_ctl_t         list_ctl;
  logic [KW-1:0]     eff_k;
  logic [KI-1:0]     rd_rank;
  logic [DIST_W-1:0] rd_dist;
  logic [IDX_W-1:0]  rd_idx;

  knn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_start(start),
    .in_data (in_data),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  knn_back #(
    .DIM_MAX  (DIM_MAX),
    .K_MAX    (K_MAX),
    .TRAIN_MAX(TRAIN_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .list_ctl  (list_ctl),
    .eff_k     (eff_k),
    .rd_rank   (rd_rank),
    .rd_dist   (rd_dist),
    .rd_idx    (rd_idx),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  knn_list #(
    .K_MAX(K_MAX)
  ) u_list (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (list_ctl),
    .eff_k  (eff_k),
    .rd_rank(rd_rank),
    .rd_dist(rd_dist),
    .rd_idx (rd_idx)
  );

endmodule

/* test/brute_force_knn_search_test.sv */
`timescale 1ns / 100ps

module brute_force_knn_search_test;
  import knn_pkg::*;

  localparam int          RANDOM_ITEMS = 205;
  localparam int          DRAIN_CYCLES = 24;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam logic [63:0] DIST_CAP     = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    bit                    set_regs;
    action_t               act;
    logic [COORD_BITS-1:0] coord;
    logic [CFG_W-1:0]      k_val;
    logic [CFG_W-1:0]      d_val;
    bit                    pinned;
    knn_out_t              want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  knn_in_t              in_data = '0;
  logic                 busy;
  logic                 out_strobe;
  knn_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  brute_force_knn_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the search state
  logic [COORD_BITS-1:0] query_mem [DIM_MAX_DEF];
  bit                    query_valid [DIM_MAX_DEF];
  int unsigned           query_fill;
  int unsigned           coord_pos;
  logic [DIST_W-1:0]     dist_acc;
  int unsigned           point_count;
  logic [DIST_W-1:0]     best_dist [K_MAX_DEF];
  logic [IDX_W-1:0]      best_idx [K_MAX_DEF];
  logic [KCFG_W-1:0]     k_reg;
  logic [DCFG_W-1:0]     dims_reg;

  knn_out_t    pending_ranks[$];
  bit          pin_next;
  knn_out_t    pin_value;
  int          burst_left;
  int unsigned bad_results;
  int unsigned cycle_count;
  script_row_t script[$];

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    return (k_reg > K_MAX_DEF) ? K_MAX_DEF : int'(k_reg);
  endfunction

  function automatic int eff_dims();
    if (dims_reg == 0) return 1;
    return (dims_reg > DIM_MAX_DEF) ? DIM_MAX_DEF : int'(dims_reg);
  endfunction

  function automatic void wipe_search();
    query_fill = 0;
    coord_pos = 0;
    dist_acc = '0;
    point_count = 0;
    for (int i = 0; i < K_MAX_DEF; i++) begin
      best_dist[i] = DIST_ONES;
      best_idx[i] = '0;
    end
  endfunction

  // Ties stay behind the earlier index: bubble past strictly larger entries only.
  function automatic void offer_point(logic [DIST_W-1:0] d, logic [IDX_W-1:0] idx);
    int                j;
    logic [DIST_W-1:0] td;
    logic [IDX_W-1:0]  ti;
    j = eff_k() - 1;
    if (best_dist[j] <= d) return;
    best_dist[j] = d;
    best_idx[j] = idx;
    while (j > 0 && best_dist[j] < best_dist[j-1]) begin
      td = best_dist[j];
      ti = best_idx[j];
      best_dist[j] = best_dist[j-1];
      best_idx[j] = best_idx[j-1];
      best_dist[j-1] = td;
      best_idx[j-1] = ti;
      j--;
    end
  endfunction

  function automatic void track_command(knn_in_t cmd);
    logic [63:0] a, b, mag, term, sum;
    knn_out_t    rank;
    case (cmd.action)
      ACT_CLEAR: wipe_search();
      ACT_QUERY: begin
        if (query_fill < DIM_MAX_DEF) begin
          query_mem[query_fill] = cmd.coord_value ^ 16'h8000;
          query_valid[query_fill] = 1'b1;
          query_fill++;
        end
      end
      ACT_TRAIN: begin
        if (point_count < TRAIN_MAX_DEF) begin
          a = 64'(cmd.coord_value ^ 16'h8000);
          b = (coord_pos < DIM_MAX_DEF) ? 64'(query_mem[coord_pos]) : 64'd0;
          mag = (a >= b) ? a - b : b - a;
          if (mag >= (64'd1 << 20)) term = DIST_CAP;
          else begin
            term = mag * mag;
            if (term > DIST_CAP) term = DIST_CAP;
          end
          sum = 64'(dist_acc) + term;
          dist_acc = (sum > DIST_CAP) ? DIST_ONES : sum[DIST_W-1:0];
          coord_pos++;
          if (coord_pos >= eff_dims()) begin
            offer_point(dist_acc, point_count[IDX_W-1:0]);
            point_count++;
            dist_acc = '0;
            coord_pos = 0;
          end
        end
      end
      ACT_EMIT: begin
        if (pin_next) begin
          pending_ranks.push_back(pin_value);
          pin_next = 1'b0;
        end else begin
          for (int r = 0; r < eff_k(); r++) begin
            rank.neighbor_index = best_idx[r];
            rank.neighbor_distance = best_dist[r];
            rank.last_result = (r + 1 == eff_k());
            pending_ranks.push_back(rank);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 6)) - 16'd3;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic script_row_t cmd_row(action_t act, logic [COORD_BITS-1:0] coord);
    script_row_t r;
    r = '0;
    r.act = act;
    r.coord = coord;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_W-1:0] k, logic [CFG_W-1:0] d);
    script_row_t r;
    r = '0;
    r.set_regs = 1'b1;
    r.k_val = k;
    r.d_val = d;
    return r;
  endfunction

  function automatic script_row_t pinned_row(knn_out_t want);
    script_row_t r;
    r = '0;
    r.act = ACT_EMIT;
    r.pinned = 1'b1;
    r.want = want;
    return r;
  endfunction

  // Hold start until the transfer, then maybe drop it for a random gap.
  task automatic push_cmd(input action_t act, input logic [COORD_BITS-1:0] coord);
    knn_in_t cmd;
    cmd.action = act;
    cmd.coord_value = coord;
    start <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    track_command(cmd);
    if (burst_left > 0) burst_left--;
    else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= REG_K_COUNT;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= REG_DIMS;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    k_reg = k[KCFG_W-1:0];
    dims_reg = d[DCFG_W-1:0];
  endtask

  always @(posedge clk) begin : watch_results
    knn_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_ranks.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: idx %0d dist %0d last %0b",
                   out_data.neighbor_index, out_data.neighbor_distance, out_data.last_result);
      end else begin
        want = pending_ranks.pop_front();
        if (out_data !== want) begin
          bad_results++;
          if (bad_results <= 10)
            $display("rank mismatch: idx %0d/%0d dist %0d/%0d last %0b/%0b (expected/actual)",
                     want.neighbor_index, out_data.neighbor_index,
                     want.neighbor_distance, out_data.neighbor_distance,
                     want.last_result, out_data.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0]      kv, dv;
    action_t               act;
    int                    n, npts, rand_sent;
    bit                    first_phase;

    for (int i = 0; i < DIM_MAX_DEF; i++) begin
      query_mem[i] = '0;
      query_valid[i] = 1'b0;
    end
    wipe_search();
    k_reg = 1;
    dims_reg = 1;
    pin_next = 1'b0;
    burst_left = 0;
    bad_results = 0;
    cycle_count = 0;

    script.push_back(pinned_row({16'd0, DIST_ONES, 1'b1}));
    script.push_back(cfg_row(7'd0, 7'd1));
    script.push_back(pinned_row({16'd0, DIST_ONES, 1'b1}));
    script.push_back(cmd_row(ACT_QUERY, 16'h8000));
    script.push_back(cmd_row(ACT_TRAIN, 16'h7fff));
    script.push_back(cmd_row(ACT_TRAIN, 16'h8000));
    script.push_back(pinned_row({16'd1, 39'd0, 1'b1}));
    script.push_back(cfg_row(7'd31, 7'd0));
    script.push_back(cmd_row(ACT_TRAIN, 16'hffff));
    script.push_back(cmd_row(ACT_EMIT, 16'h0000));
    script.push_back(cmd_row(ACT_CLEAR, 16'h0000));
    script.push_back(cmd_row(ACT_QUERY, 16'h7fff));
    script.push_back(cmd_row(ACT_QUERY, 16'h0000));
    script.push_back(cmd_row(ACT_QUERY, 16'hffff));
    script.push_back(cmd_row(ACT_QUERY, 16'h0001));
    script.push_back(cfg_row(7'd16, 7'd4));
    script.push_back(cmd_row(ACT_TRAIN, 16'h8000));
    script.push_back(cmd_row(ACT_TRAIN, 16'h7fff));
    // shrink dims in the middle of a point: the next coordinate closes it
    script.push_back(cfg_row(7'd16, 7'd2));
    script.push_back(cmd_row(ACT_TRAIN, 16'h1234));
    script.push_back(cfg_row(7'd2, 7'd3));
    script.push_back(cmd_row(ACT_TRAIN, 16'h7fff));
    script.push_back(cmd_row(ACT_TRAIN, 16'h0000));
    script.push_back(cmd_row(ACT_TRAIN, 16'hffff));
    script.push_back(cmd_row(ACT_EMIT, 16'h0000));
    script.push_back(cmd_row(ACT_CLEAR, 16'hffff));
    script.push_back(cmd_row(ACT_EMIT, 16'h0000));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].set_regs) begin
        settle();
        set_regs(script[i].k_val, script[i].d_val);
      end else begin
        pin_next = script[i].pinned;
        pin_value = script[i].want;
        push_cmd(script[i].act, script[i].coord);
      end
    end

    rand_sent = 0;
    first_phase = 1'b1;
    while (rand_sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0: kv = 7'd0;
        1: kv = 7'd1;
        2: kv = 7'd16;
        3: kv = 7'h7f;
        default: kv = 7'($urandom_range(1, 16));
      endcase
      if (first_phase) dv = 7'h7f;
      else begin
        case ($urandom_range(0, 15))
          0: dv = 7'd64;
          1: dv = 7'd0;
          2: dv = 7'd1;
          default: dv = 7'($urandom_range(2, 4));
        endcase
      end
      first_phase = 1'b0;
      set_regs(kv, dv);
      if ($urandom_range(0, 9) < 8) begin
        push_cmd(ACT_CLEAR, rand_coord());
        // at full dims run past the query store to hit its overflow
        n = eff_dims() + ((eff_dims() == DIM_MAX_DEF) ? $urandom_range(1, 3) : $urandom_range(0, 1));
        repeat (n) push_cmd(ACT_QUERY, rand_coord());
        npts = (eff_dims() > 8) ? 1 : $urandom_range(2, 10);
        rand_sent += n + 1;
        repeat (npts) begin
          repeat (eff_dims()) push_cmd(ACT_TRAIN, rand_coord());
          rand_sent += eff_dims();
          if ($urandom_range(0, 7) == 0) begin
            push_cmd(ACT_EMIT, rand_coord());
            rand_sent++;
          end
        end
        push_cmd(ACT_EMIT, rand_coord());
        rand_sent++;
      end else begin
        repeat ($urandom_range(5, 15)) begin
          act = action_t'($urandom_range(0, 3));
          // never read a query entry that was not written since reset
          if (act == ACT_TRAIN && !query_valid[coord_pos]) act = ACT_QUERY;
          push_cmd(act, rand_coord());
          rand_sent++;
        end
      end
    end

    settle();

    if (bad_results == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
